FILE: rtl/ims_pkg.sv
// Shared types, constants and helper functions of the IMU stationary detector.
`default_nettype none

package ims_pkg;

    // Field widths
    localparam int DATA_W   = 16;          // raw sensor count
    localparam int MAG_W    = 17;          // window magnitude slot
    localparam int ROOT_W   = 16;          // square root result
    localparam int RAD_W    = 32;          // squared magnitude
    localparam int BIAS_W   = 32;          // Q15.16 bias state
    localparam int FRAC_W   = 16;          // fraction bits of the bias state
    localparam int CFG_W    = 16;          // widest configuration register
    localparam int CFG_IDX_W = 2;
    localparam int NUM_AXES = 3;

    // Stream payload widths (whole bytes)
    localparam int IN_DATA_W  = 6 * DATA_W;                 // 96
    localparam int OUT_DATA_W = 56;                         // 1 + 3*16 padded to 7 bytes

    // Defaults
    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int MIN_FILL         = 5;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd64;
    localparam logic [CFG_W-1:0] ALPHA_RST     = 16'd655;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_ALPHA     = 2'd1
    } t_cfg_idx;

    // Item kinds
    typedef enum logic {
        FUNC_ACCEL = 1'b0,
        FUNC_GYRO  = 1'b1
    } t_func;

    // Square-root unit handshake
    typedef struct packed {
        logic                start;
        logic [RAD_W-1:0]    radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic                done;
        logic [ROOT_W-1:0]   root;
    } t_sqrt_rsp;

    // Integer part of a Q15.16 bias, rounded half up
    function automatic logic [DATA_W-1:0] round_bias(input logic [BIAS_W-1:0] b);
        logic [BIAS_W:0] t;
        t = {b[BIAS_W-1], b} + (BIAS_W+1)'(32768);
        return t[BIAS_W-1:FRAC_W];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ims_ram.sv
// Generic single-port synchronous RAM with registered read data.
`default_nettype none

module ims_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/ims_isqrt.sv
// Iterative floor square root, one result bit per cycle.
`default_nettype none

module ims_isqrt (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ims_pkg::t_sqrt_req  i_req,
    output ims_pkg::t_sqrt_rsp       o_rsp
);

    localparam int ROOT_W = ims_pkg::ROOT_W;
    localparam int RAD_W  = ims_pkg::RAD_W;
    localparam int REM_W  = ROOT_W + 1;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              take;
    logic [REM_W+1:0]  rem_sub;

    // One digit pair per step: bring down two bits, try (root<<2)|1
    always_comb begin
        rem_sh  = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial   = {1'b0, r_root, 2'b01};
        take    = (rem_sh >= trial);
        rem_sub = take ? (rem_sh - trial) : rem_sh;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_req.radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= rem_sub[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], take};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

`default_nettype wire

FILE: rtl/imu_stationary_detector.sv
// Top level of the IMU stationary detector: sequencer, window and bias datapath.
//
// Each input beat yields exactly one result beat. An accelerometer beat passes through
// three squaring steps, the square-root unit (start, 16 steps, done), the window update
// in the magnitude RAM (MSQ, UPD), the variance test (FMUL1, FMUL2, FCMP), a readout of
// the bias RAM and the load of the output register. A gyro beat makes three
// read-modify-write passes through the single-port bias RAM (read, difference, multiply,
// write per axis), then the same test, readout and load. One beat is worked on at a
// time; the next is accepted in the cycle after the result is loaded. The output
// register holds a result until taken; a result still waiting there stalls only the
// load of the following one.
// The magnitude window lives in a WINDOW_DEPTH x 17 RAM whose old slot value is used
// only once the window is full; the three Q15.16 biases live in a 3 x 32 RAM guarded by
// valid bits, so no clearing pass follows reset.
`default_nettype none

module imu_stationary_detector #(
    parameter int WINDOW_DEPTH = ims_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [ims_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [ims_pkg::CFG_W-1:0]        i_cfg_data,
    // Input stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each, from bit 0)
    input  wire logic [ims_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // func
    input  wire logic                             i_s_axis_tuser,
    // Result stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // is_static, bias_x_out, bias_y_out, bias_z_out, 7 zero pad bits
    output logic [ims_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata
);

    localparam int DATA_W = ims_pkg::DATA_W;
    localparam int MAG_W  = ims_pkg::MAG_W;
    localparam int BIAS_W = ims_pkg::BIAS_W;
    localparam int AW     = $clog2(WINDOW_DEPTH);
    localparam int CW     = $clog2(WINDOW_DEPTH + 1);
    localparam int SW     = MAG_W + CW;            // running sum
    localparam int MSQ_W  = 2 * MAG_W;             // one squared magnitude
    localparam int SQW    = MSQ_W + CW;            // running sum of squares
    localparam int PW     = 2 * SW;                // variance products
    localparam int LIM_W  = ims_pkg::CFG_W + CW;
    localparam int BAW    = $clog2(ims_pkg::NUM_AXES);
    localparam int DIFF_W = BIAS_W + 1;
    // alpha (17 bit signed) times the upper difference bits
    localparam int PHI_W  = ims_pkg::CFG_W + 1 + DIFF_W - ims_pkg::FRAC_W;
    localparam int PROD_W = PHI_W + ims_pkg::FRAC_W + 1;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_SQ    = 14'b00000000000010,
        ST_SQRT  = 14'b00000000000100,
        ST_MSQ   = 14'b00000000001000,
        ST_UPD   = 14'b00000000010000,
        ST_BRD   = 14'b00000000100000,
        ST_BDIFF = 14'b00000001000000,
        ST_BMUL  = 14'b00000010000000,
        ST_BWR   = 14'b00000100000000,
        ST_FMUL1 = 14'b00001000000000,
        ST_FMUL2 = 14'b00010000000000,
        ST_FCMP  = 14'b00100000000000,
        ST_ORD   = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [ims_pkg::CFG_W-1:0] r_thr;
    logic [ims_pkg::CFG_W-1:0] r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= ims_pkg::THRESHOLD_RST;
            r_alpha <= ims_pkg::ALPHA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ims_pkg::CFG_THRESHOLD: r_thr   <= i_cfg_data;
                ims_pkg::CFG_ALPHA:     r_alpha <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath registers
    logic [ims_pkg::IN_DATA_W-1:0] r_in;
    logic [1:0]                    r_step;
    logic [ims_pkg::RAD_W-1:0]     r_m2;
    logic                          r_sqrt_start;
    logic [MAG_W-1:0]              r_mag;
    logic [MAG_W-1:0]              r_old;
    logic [MSQ_W-1:0]              r_msq;
    logic [MSQ_W-1:0]              r_osq;
    logic [AW-1:0]                 r_head;
    logic [CW-1:0]                 r_fill;
    logic [SW-1:0]                 r_sum;
    logic [SQW-1:0]                r_sumsq;
    logic [PW-1:0]                 r_p1;
    logic [PW-1:0]                 r_p2;
    logic [LIM_W-1:0]              r_lim;
    logic [2*LIM_W-1:0]            r_lim2;
    logic                          r_flag;
    logic [ims_pkg::NUM_AXES-1:0]  r_bvalid;
    logic [BIAS_W-1:0]             r_b;
    logic signed [DIFF_W-1:0]      r_diff;
    logic [BIAS_W-1:0]             r_plo;
    logic signed [PHI_W-1:0]       r_phi;
    logic [DATA_W-1:0]             r_bx;
    logic [DATA_W-1:0]             r_by;
    logic [DATA_W-1:0]             r_bz;
    logic                          r_out_valid;
    logic [ims_pkg::OUT_DATA_W-1:0] r_out_data;

    // Memory ports
    logic              ring_we;
    logic              ring_re;
    logic [MAG_W-1:0]  ring_rdata;
    logic              bram_we;
    logic              bram_re;
    logic [BAW-1:0]    bram_addr;
    logic [BIAS_W-1:0] bram_wdata;
    logic [BIAS_W-1:0] bram_rdata;

    ims_pkg::t_sqrt_req sqrt_req;
    ims_pkg::t_sqrt_rsp sqrt_rsp;

    logic accept;
    logic full;
    logic out_free;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign full     = (r_fill == CW'(WINDOW_DEPTH));
    assign out_free = !r_out_valid || i_m_axis_tready;

    // Magnitude window RAM: old slot read at acceptance, new value written in update
    assign ring_re = accept;
    assign ring_we = (r_state == ST_UPD);

    ims_ram #(
        .WIDTH (MAG_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_re    (ring_re),
        .i_addr  (r_head),
        .i_wdata (r_mag),
        .o_rdata (ring_rdata)
    );

    // Bias RAM: one axis per pass, readout walks the entries again
    logic [BIAS_W-1:0] bias_new;
    logic [1:0]        rd_idx;
    logic              rd_valid;
    logic [BIAS_W-1:0] bias_cur;

    assign bram_addr  = r_step[BAW-1:0];
    assign bram_re    = (r_state == ST_BRD) ||
                        ((r_state == ST_ORD) && (r_step != 2'(ims_pkg::NUM_AXES)));
    assign bram_we    = (r_state == ST_BWR);
    assign bram_wdata = bias_new;

    ims_ram #(
        .WIDTH (BIAS_W),
        .DEPTH (ims_pkg::NUM_AXES)
    ) u_bias_ram (
        .i_clk   (i_clk),
        .i_we    (bram_we),
        .i_re    (bram_re),
        .i_addr  (bram_addr),
        .i_wdata (bram_wdata),
        .o_rdata (bram_rdata)
    );

    // Entries never written read as zero
    always_comb begin
        rd_idx = (r_state == ST_ORD) ? (r_step - 2'd1) : r_step;
        case (rd_idx)
            2'd0:    rd_valid = r_bvalid[0];
            2'd1:    rd_valid = r_bvalid[1];
            2'd2:    rd_valid = r_bvalid[2];
            default: rd_valid = 1'b0;
        endcase
        bias_cur = rd_valid ? bram_rdata : '0;
    end

    // Square-root unit
    assign sqrt_req.start    = r_sqrt_start;
    assign sqrt_req.radicand = r_m2;

    ims_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    // Operand selection and arithmetic
    logic signed [DATA_W-1:0]   acc_sel;
    logic signed [DATA_W-1:0]   gyr_sel;
    logic signed [2*DATA_W-1:0] acc_sq;
    logic signed [DIFF_W-1:0]   diff_w;
    logic signed [PROD_W-1:0]   prod_w;
    logic [PW-1:0]              var_w;

    always_comb begin
        acc_sel = $signed(r_in[r_step * DATA_W +: DATA_W]);
        gyr_sel = $signed(r_in[(r_step + 3'd3) * DATA_W +: DATA_W]);
        acc_sq  = acc_sel * acc_sel;
        diff_w  = $signed({gyr_sel[DATA_W-1], gyr_sel, {ims_pkg::FRAC_W{1'b0}}})
                - $signed({bias_cur[BIAS_W-1], bias_cur});
        // alpha*diff = (alpha*diff_hi << 16) + alpha*diff_lo, plus half for rounding
        prod_w  = $signed({r_phi[PHI_W-1], r_phi, {ims_pkg::FRAC_W{1'b0}}})
                + $signed({{(PROD_W-BIAS_W){1'b0}}, r_plo})
                + PROD_W'(32768);
        bias_new = r_b + prod_w[ims_pkg::FRAC_W +: BIAS_W];
        var_w   = (r_p1 >= r_p2) ? (r_p1 - r_p2) : '0;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_sqrt_start <= 1'b0;
            r_head       <= '0;
            r_fill       <= '0;
            r_sum        <= '0;
            r_sumsq      <= '0;
            r_bvalid     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_sqrt_start <= 1'b0;
            // Taken beat empties the output register unless a new result loads it
            if (r_out_valid && i_m_axis_tready && !((r_state == ST_DONE) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_step  <= '0;
                        r_state <= (i_s_axis_tuser == ims_pkg::FUNC_ACCEL) ? ST_SQ : ST_BRD;
                    end
                end
                ST_SQ: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd2) begin
                        r_sqrt_start <= 1'b1;
                        r_state      <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (sqrt_rsp.done) begin
                        r_state <= ST_MSQ;
                    end
                end
                ST_MSQ: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    // Drop the oldest slot only once the window is full
                    if (full) begin
                        r_sum   <= r_sum - SW'(r_old) + SW'(r_mag);
                        r_sumsq <= r_sumsq - SQW'(r_osq) + SQW'(r_msq);
                    end else begin
                        r_fill  <= r_fill + CW'(1);
                        r_sum   <= r_sum + SW'(r_mag);
                        r_sumsq <= r_sumsq + SQW'(r_msq);
                    end
                    r_head  <= (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + AW'(1);
                    r_state <= ST_FMUL1;
                end
                ST_BRD: begin
                    r_state <= ST_BDIFF;
                end
                ST_BDIFF: begin
                    r_state <= ST_BMUL;
                end
                ST_BMUL: begin
                    r_state <= ST_BWR;
                end
                ST_BWR: begin
                    case (r_step)
                        2'd0:    r_bvalid[0] <= 1'b1;
                        2'd1:    r_bvalid[1] <= 1'b1;
                        default: r_bvalid[2] <= 1'b1;
                    endcase
                    if (r_step == 2'(ims_pkg::NUM_AXES - 1)) begin
                        r_state <= ST_FMUL1;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= ST_BRD;
                    end
                end
                ST_FMUL1: begin
                    r_state <= ST_FMUL2;
                end
                ST_FMUL2: begin
                    r_state <= ST_FCMP;
                end
                ST_FCMP: begin
                    r_step  <= '0;
                    r_state <= ST_ORD;
                end
                ST_ORD: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'(ims_pkg::NUM_AXES)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_s_axis_tdata;
            r_m2 <= '0;
        end
        if (r_state == ST_SQ) begin
            r_m2 <= r_m2 + ims_pkg::RAD_W'(unsigned'(acc_sq));
            if (r_step == 2'd0) begin
                r_old <= ring_rdata;
            end
        end
        if ((r_state == ST_SQRT) && sqrt_rsp.done) begin
            r_mag <= {1'b0, sqrt_rsp.root};
        end
        if (r_state == ST_MSQ) begin
            r_msq <= r_mag * r_mag;
            r_osq <= r_old * r_old;
        end
        // Bias pass: fetch, difference, split multiply, write back
        if (r_state == ST_BDIFF) begin
            r_b    <= bias_cur;
            r_diff <= diff_w;
        end
        if (r_state == ST_BMUL) begin
            r_plo <= r_alpha * r_diff[ims_pkg::FRAC_W-1:0];
            r_phi <= $signed({1'b0, r_alpha}) * $signed(r_diff[DIFF_W-1:ims_pkg::FRAC_W]);
        end
        // Variance test: n*sumsq - sum^2 < (thr*n)^2
        if (r_state == ST_FMUL1) begin
            r_p1  <= r_fill * r_sumsq;
            r_lim <= r_thr * r_fill;
        end
        if (r_state == ST_FMUL2) begin
            r_p2   <= r_sum * r_sum;
            r_lim2 <= r_lim * r_lim;
        end
        if (r_state == ST_FCMP) begin
            r_flag <= (r_fill >= CW'(ims_pkg::MIN_FILL)) && (PW'(var_w) < PW'(r_lim2));
        end
        // Readout: capture the entry read in the previous cycle
        if (r_state == ST_ORD) begin
            case (r_step)
                2'd1:    r_bx <= ims_pkg::round_bias(bias_cur);
                2'd2:    r_by <= ims_pkg::round_bias(bias_cur);
                2'd3:    r_bz <= ims_pkg::round_bias(bias_cur);
                default: ;
            endcase
        end
        if ((r_state == ST_DONE) && out_free) begin
            r_out_data <= {7'b0, r_bz, r_by, r_bx, r_flag};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(WINDOW_DEPTH))
        else $error("window fill count above depth");

    a_head_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full |-> (CW'(r_head) == r_fill))
        else $error("head pointer out of step with fill count before wrap");

    a_sqrt_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_rsp.done |-> (r_state == ST_SQRT))
        else $error("square root finished outside its wait state");

    a_short_window_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_fill < CW'(ims_pkg::MIN_FILL))) |-> !o_m_axis_tdata[0])
        else $error("stationary flag set with too few magnitudes");

endmodule

`default_nettype wire

FILE: tb/imu_stationary_detector_test.sv
// Self-checking testbench for the IMU stationary detector: window flag and gyro bias per beat.
module imu_stationary_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W          = ims_pkg::DATA_W;
    localparam int MAG_W           = ims_pkg::MAG_W;
    localparam int ROOT_W          = ims_pkg::ROOT_W;
    localparam int FRAC_W          = ims_pkg::FRAC_W;
    localparam int CFG_W           = ims_pkg::CFG_W;
    localparam int CFG_IDX_W       = ims_pkg::CFG_IDX_W;
    localparam int NUM_AXES        = ims_pkg::NUM_AXES;
    localparam int IN_DATA_W       = ims_pkg::IN_DATA_W;
    localparam int OUT_DATA_W      = ims_pkg::OUT_DATA_W;
    localparam int MIN_FILL        = ims_pkg::MIN_FILL;
    localparam int WINDOW_SLOTS    = ims_pkg::WINDOW_DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 150;
    localparam int REPORT_LINES    = 100;
    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        ims_pkg::t_func                    func;
        logic [NUM_AXES-1:0][DATA_W-1:0]   gyro;
        logic [NUM_AXES-1:0][DATA_W-1:0]   accel;
    } t_imu_item;

    typedef struct packed {
        logic                              is_static;
        logic [NUM_AXES-1:0][DATA_W-1:0]   bias;
    } t_detector_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  i_s_axis_tuser = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    // Predicted detector state
    logic [MAG_W-1:0]  win_mag [WINDOW_SLOTS];
    int unsigned       win_head = 0;
    int unsigned       win_fill = 0;
    longint unsigned   win_sum = 0;
    longint unsigned   win_sq_sum = 0;
    longint            bias_q16 [NUM_AXES] = '{0, 0, 0};
    longint            thr_reg = ims_pkg::THRESHOLD_RST;
    longint            alpha_reg = ims_pkg::ALPHA_RST;
    t_detector_result  expected_results [$];

    int  mismatch_count = 0;
    int  quiet_cycles = 0;
    bit  sender_idles = 1'b1;
    bit  ready_idles = 1'b1;
    bit  hold_off_go = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;

    // Random stimulus shape of the current phase
    int  grav [NUM_AXES] = '{0, 0, 16384};
    int  noise_amp = 16;
    int  gyro_center [NUM_AXES] = '{0, 0, 0};

    imu_stationary_detector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bit-serial floor square root
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root, trial;
        int b;
        root = 0;
        for (b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic int clamp16(input int v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    function automatic int rand_noise(input int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    // Unused fields always carry random bits
    function automatic t_imu_item accel_item(input int x, input int y, input int z);
        t_imu_item it;
        it.func  = ims_pkg::FUNC_ACCEL;
        it.accel = {DATA_W'(z), DATA_W'(y), DATA_W'(x)};
        it.gyro  = 48'({$urandom, $urandom});
        return it;
    endfunction

    function automatic t_imu_item gyro_item(input int x, input int y, input int z);
        t_imu_item it;
        it.func  = ims_pkg::FUNC_GYRO;
        it.gyro  = {DATA_W'(z), DATA_W'(y), DATA_W'(x)};
        it.accel = 48'({$urandom, $urandom});
        return it;
    endfunction

    // Mostly a steady gravity vector with noise, some raw noise, some gyro beats
    function automatic t_imu_item random_item();
        int kind, a;
        int v [NUM_AXES];
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            for (a = 0; a < NUM_AXES; a++) v[a] = clamp16(grav[a] + rand_noise(noise_amp));
            return accel_item(v[0], v[1], v[2]);
        end
        if (kind == 6) return accel_item(int'($urandom), int'($urandom), int'($urandom));
        if (kind == 7) return gyro_item(int'($urandom), int'($urandom), int'($urandom));
        for (a = 0; a < NUM_AXES; a++) v[a] = clamp16(gyro_center[a] + rand_noise(200));
        return gyro_item(v[0], v[1], v[2]);
    endfunction

    function automatic int sender_gap();
        int r;
        if (!sender_idles) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // Window update or bias average, then the flag and rounded biases
    task automatic advance_detector(input t_imu_item it);
        longint          m2, prod, lhs, sq, lim;
        longint unsigned mag, old;
        t_detector_result res;
        int a;
        if (it.func == ims_pkg::FUNC_ACCEL) begin
            m2 = 0;
            for (a = 0; a < NUM_AXES; a++)
                m2 += longint'($signed(it.accel[a])) * longint'($signed(it.accel[a]));
            mag = floor_root(m2);
            if (win_fill == WINDOW_SLOTS) begin
                old = win_mag[win_head];
                win_sum -= old;
                win_sq_sum -= old * old;
            end else begin
                win_fill++;
            end
            win_mag[win_head] = MAG_W'(mag);
            win_sum += mag;
            win_sq_sum += mag * mag;
            win_head = (win_head + 1) % WINDOW_SLOTS;
        end else begin
            for (a = 0; a < NUM_AXES; a++) begin
                prod = alpha_reg * (longint'($signed(it.gyro[a])) * 65536 - bias_q16[a]);
                bias_q16[a] += (prod + 32768) >>> FRAC_W;
            end
        end
        res.is_static = 1'b0;
        if (win_fill >= MIN_FILL) begin
            lhs = longint'(win_fill) * longint'(win_sq_sum);
            sq  = longint'(win_sum * win_sum);
            lhs = (lhs >= sq) ? lhs - sq : 0;
            lim = thr_reg * longint'(win_fill);
            res.is_static = (lhs < lim * lim);
        end
        for (a = 0; a < NUM_AXES; a++)
            res.bias[a] = DATA_W'((bias_q16[a] + 32768) >>> FRAC_W);
        expected_results.push_back(res);
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_LINES) $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Offer one beat after a random gap; valid stays high when there is no gap
    task automatic send_item(input t_imu_item it);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {it.gyro, it.accel};
        i_s_axis_tuser  = it.func;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        advance_detector(it);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == ims_pkg::CFG_THRESHOLD) thr_reg = value;
        else if (idx == ims_pkg::CFG_ALPHA) alpha_reg = value;
    endtask

    // Flag stays low below five magnitudes, then rises on a constant window
    task automatic test_window_fill();
        int k;
        send_item(gyro_item(100, -100, 0));
        for (k = 0; k < MIN_FILL - 1; k++) send_item(accel_item(0, 0, 16384));
        send_item(gyro_item(0, 0, 0));
        send_item(accel_item(0, 16384, 0));
        send_item(accel_item(0, 0, -16384));
    endtask

    task automatic test_field_extremes();
        send_item(accel_item(-32768, -32768, -32768));
        send_item(accel_item(32767, 32767, 32767));
        send_item(accel_item(-32768, 0, 0));
        send_item(accel_item(0, 0, 0));
        send_item(gyro_item(32767, 32767, 32767));
        send_item(gyro_item(-32768, -32768, -32768));
        send_item(gyro_item(0, -1, 1));
    endtask

    task automatic test_threshold_limits();
        wait_drained();
        write_register(ims_pkg::CFG_THRESHOLD, '0);
        send_item(accel_item(0, 0, 16384));
        send_item(accel_item(0, 0, 16384));
        wait_drained();
        write_register(ims_pkg::CFG_THRESHOLD, '1);
        send_item(accel_item(int'($urandom), int'($urandom), int'($urandom)));
        send_item(accel_item(-32768, 0, 0));
        wait_drained();
        // out-of-range indexes leave both registers untouched
        write_register(CFG_SPARE_A, '0);
        write_register(CFG_SPARE_B, '0);
        send_item(accel_item(0, 0, 0));
        wait_drained();
        write_register(ims_pkg::CFG_THRESHOLD, ims_pkg::THRESHOLD_RST);
    endtask

    task automatic test_alpha_limits();
        wait_drained();
        write_register(ims_pkg::CFG_ALPHA, '0);
        send_item(gyro_item(32767, -32768, 1234));
        wait_drained();
        write_register(ims_pkg::CFG_ALPHA, '1);
        send_item(gyro_item(32767, 32767, 32767));
        send_item(gyro_item(-32768, -32768, -32768));
        wait_drained();
        write_register(ims_pkg::CFG_ALPHA, 16'd32768);
        send_item(gyro_item(-1, 1, 0));
        wait_drained();
        write_register(ims_pkg::CFG_ALPHA, ims_pkg::ALPHA_RST);
    endtask

    // Receiver holds off while beats keep coming, then the sender waits for all results
    task automatic test_output_backpressure();
        int k;
        wait_drained();
        sender_idles = 1'b0;
        hold_off_go  = 1'b1;
        for (k = 0; k < 12; k++) send_item(random_item());
        wait_drained();
        sender_idles = 1'b1;
    endtask

    task automatic test_random_phases();
        int p, a, k;
        for (p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            case ($urandom_range(0, 3))
                0:       write_register(ims_pkg::CFG_THRESHOLD, '0);
                1:       write_register(ims_pkg::CFG_THRESHOLD, '1);
                2:       write_register(ims_pkg::CFG_THRESHOLD,
                                        CFG_W'($urandom_range(1, 200)));
                default: write_register(ims_pkg::CFG_THRESHOLD, CFG_W'($urandom));
            endcase
            case ($urandom_range(0, 3))
                0:       write_register(ims_pkg::CFG_ALPHA, '0);
                1:       write_register(ims_pkg::CFG_ALPHA, '1);
                2:       write_register(ims_pkg::CFG_ALPHA, CFG_W'($urandom_range(1, 4000)));
                default: write_register(ims_pkg::CFG_ALPHA, CFG_W'($urandom));
            endcase
            for (a = 0; a < NUM_AXES; a++) begin
                grav[a]        = int'($urandom_range(0, 40000)) - 20000;
                gyro_center[a] = int'($urandom_range(0, 4000)) - 2000;
            end
            case ($urandom_range(0, 4))
                0:       noise_amp = 0;
                1:       noise_amp = 4;
                2:       noise_amp = 64;
                3:       noise_amp = 600;
                default: noise_amp = $urandom_range(0, 3000);
            endcase
            // one phase runs with no idling on either side
            sender_idles = (p != 2);
            ready_idles  = (p != 2);
            for (k = 0; k < PHASE_ITEMS; k++) send_item(random_item());
        end
        sender_idles = 1'b1;
        ready_idles  = 1'b1;
    endtask

    // Result-side ready: random stalls, stretches of none, one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_go) begin
            hold_left   = HOLD_OFF_CYCLES;
            hold_off_go = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready = 1'b0;
        end else if (!ready_idles) begin
            i_m_axis_tready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready = 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 3);
            i_m_axis_tready = 1'b0;
        end else begin
            i_m_axis_tready = 1'b1;
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_detector_result want;
        logic [DATA_W-1:0] got_bias;
        int a;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %h", o_m_axis_tdata));
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tdata[0] !== want.is_static)
                    report_mismatch($sformatf("is_static got %b want %b",
                                              o_m_axis_tdata[0], want.is_static));
                for (a = 0; a < NUM_AXES; a++) begin
                    got_bias = o_m_axis_tdata[1 + a * DATA_W +: DATA_W];
                    if (got_bias !== want.bias[a])
                        report_mismatch($sformatf("bias axis %0d got %0d want %0d", a,
                                                  $signed(got_bias), $signed(want.bias[a])));
                end
                if (o_m_axis_tdata[OUT_DATA_W-1:1 + NUM_AXES * DATA_W] !== '0)
                    report_mismatch($sformatf("pad bits not zero: %h", o_m_axis_tdata));
            end
        end
    end

    // Watchdog on cycles with no beat accepted on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready === 1'b1) ||
            (o_m_axis_tvalid === 1'b1 && i_m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_window_fill();
        test_field_extremes();
        test_threshold_limits();
        test_alpha_limits();
        test_output_backpressure();
        test_random_phases();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
